// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the flow color wheel RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/fvcw_pkg.sv =====
// Package for the flow color wheel: widths, CORDIC angle table and hue wheel.
// No dependencies.
`default_nettype none
package fvcw_pkg;
  localparam int FlowW = 24;
  localparam int FlowFracBits = 12;
  localparam int CordicSteps = 16;
  localparam int WheelSize = 55;
  localparam int CordicW = 44;

  typedef logic [7:0] chan_t;
  typedef logic [31:0] turn_t;

  function automatic turn_t turn_tab(input logic [3:0] i);
    turn_t t;
    case (i)
      4'd0: t = 32'h20000000;
      4'd1: t = 32'h12E4051D;
      4'd2: t = 32'h09FB385B;
      4'd3: t = 32'h051111D4;
      4'd4: t = 32'h028B0D43;
      4'd5: t = 32'h0145D7E1;
      4'd6: t = 32'h00A2F61E;
      4'd7: t = 32'h00517C55;
      4'd8: t = 32'h0028BE53;
      4'd9: t = 32'h00145F2E;
      4'd10: t = 32'h000A2F98;
      4'd11: t = 32'h000517CC;
      4'd12: t = 32'h00028BE6;
      4'd13: t = 32'h000145F3;
      4'd14: t = 32'h0000A2F9;
      default: t = 32'h0000517C;
    endcase
    return t;
  endfunction

  // Hue wheel entry k: red, green, blue packed as {r, g, b}.
  function automatic logic [23:0] wheel_entry(input logic [5:0] k);
    int r, g, b, kk;
    r = 0;
    g = 0;
    b = 0;
    kk = int'(k);
    if (kk < 15) begin
      r = 255;
      g = 255 * kk / 15;
    end else if (kk < 21) begin
      r = 255 - 255 * (kk - 15) / 6;
      g = 255;
    end else if (kk < 25) begin
      g = 255;
      b = 255 * (kk - 21) / 4;
    end else if (kk < 36) begin
      g = 255 - 255 * (kk - 25) / 11;
      b = 255;
    end else if (kk < 49) begin
      r = 255 * (kk - 36) / 13;
      b = 255;
    end else begin
      kk = kk - 49;
      if (kk > 5) kk = 5;
      r = 255;
      b = 255 - 255 * kk / 6;
    end
    return {r[7:0], g[7:0], b[7:0]};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/fvcw_cordic.sv =====
// Pipelined vectoring CORDIC giving the flow direction in turn units.
// Depends on fvcw_pkg; one register stage per iteration.
`default_nettype none
`include "assert_macros.svh"
module fvcw_cordic (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_vld,
  input  wire logic signed [fvcw_pkg::FlowW-1:0] u,
  input  wire logic signed [fvcw_pkg::FlowW-1:0] v,
  output logic                              out_vld,
  output fvcw_pkg::turn_t                   ang
);
  import fvcw_pkg::*;

  localparam int N = CordicSteps + 1;

  logic [N-1:0] vld_r;
  logic signed [CordicW-1:0] x_r [N];
  logic signed [CordicW-1:0] y_r [N];
  turn_t a_r [N];
  logic [N-1:0] fix_r;

  logic signed [CordicW-1:0] x0, y0;
  turn_t a0;
  logic fix0;

  // Stage zero: axis cases are taken exactly and bypass the iterations.
  always_comb begin
    x0 = CordicW'(u) <<< 16;
    y0 = CordicW'(v) <<< 16;
    a0 = '0;
    fix0 = 1'b0;
    if (v == '0) begin
      fix0 = 1'b1;
      a0 = (u > 0) ? 32'h0 : 32'h80000000;
    end else if (u == '0) begin
      fix0 = 1'b1;
      a0 = (v > 0) ? 32'h40000000 : 32'hC0000000;
    end else if (u < 0) begin
      x0 = -x0;
      y0 = -y0;
      a0 = 32'h80000000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= x0;
    y_r[0] <= y0;
    a_r[0] <= a0;
    fix_r[0] <= fix0;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_it
    always_ff @(posedge clk) begin
      fix_r[i+1] <= fix_r[i];
      if (fix_r[i]) begin
        x_r[i+1] <= x_r[i];
        y_r[i+1] <= y_r[i];
        a_r[i+1] <= a_r[i];
      end else if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + turn_tab(4'(i));
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - turn_tab(4'(i));
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign ang = a_r[N-1];

  `ASSERT_NEXT(a_vld_shift, clk, rst_n, in_vld, vld_r[0], "cordic lost a valid")
  `ASSERT_NEXT(a_out_follow, clk, rst_n, vld_r[N-2], out_vld, "cordic valid broken")
  `ASSERT_NEXT(a_axis_hold, clk, rst_n, vld_r[0] && fix_r[0], fix_r[1] && a_r[1] == $past(a_r[0]), "axis angle changed")
endmodule
`default_nettype wire

// ===== rtl/core/fvcw_mag.sv =====
// Magnitude path: squared length, range test and pipelined integer square root.
// Depends on fvcw_pkg; the range flag matches the CORDIC, the root has one stage more.
`default_nettype none
module fvcw_mag #(
  parameter int FLOW_FRAC_BITS = fvcw_pkg::FlowFracBits
) (
  input  wire logic                              clk,
  input  wire logic signed [fvcw_pkg::FlowW-1:0] u,
  input  wire logic signed [fvcw_pkg::FlowW-1:0] v,
  output logic                                   small_o,
  output logic [16:0]                            s16
);
  import fvcw_pkg::*;

  localparam int N = CordicSteps + 1;
  localparam int RW = 2 * FlowW;
  // Square root of a 34-bit value: 17 result bits, one per stage.
  localparam int QW = 34;
  localparam int SB = 17;

  logic [RW-1:0] r2;
  logic [QW-1:0] q;
  logic [RW-1:0] one2;

  always_comb begin
    r2 = $unsigned(RW'(u) * RW'(u)) + $unsigned(RW'(v) * RW'(v));
    one2 = '0;
    one2[2*FLOW_FRAC_BITS] = 1'b1;
    if (2 * FLOW_FRAC_BITS <= 32) q = QW'(r2 << (32 - 2 * FLOW_FRAC_BITS));
    else q = QW'(r2 >> (2 * FLOW_FRAC_BITS - 32));
  end

  // Restoring square root: rem/root per stage, one result bit each.
  logic [QW-1:0] n_r [SB+1];
  logic [SB-1:0] rt_r [SB+1];
  logic [N-1:0] sm_r;

  always_ff @(posedge clk) begin
    n_r[0] <= q;
    rt_r[0] <= '0;
    sm_r <= {sm_r[N-2:0], (r2 <= one2)};
  end

  for (genvar i = 0; i < SB; i++) begin : g_sq
    localparam int B = 2 * (SB - 1 - i);
    logic [QW+1:0] tr;
    always_comb tr = (QW+2)'({rt_r[i], 2'b01}) << B;
    always_ff @(posedge clk) begin
      if ((QW+2)'(n_r[i]) >= tr) begin
        n_r[i+1] <= QW'((QW+2)'(n_r[i]) - tr);
        rt_r[i+1] <= {rt_r[i][SB-2:0], 1'b1};
      end else begin
        n_r[i+1] <= n_r[i];
        rt_r[i+1] <= {rt_r[i][SB-2:0], 1'b0};
      end
    end
  end

  assign small_o = sm_r[N-1];
  assign s16 = (rt_r[SB] > 17'd65536) ? 17'd65536 : rt_r[SB];
endmodule
`default_nettype wire

// ===== rtl/core/fvcw_color.sv =====
// Color stage: wheel lookup, blend, and fade or dim by the vector length.
// Depends on fvcw_pkg; three register stages.
`default_nettype none
`include "assert_macros.svh"
module fvcw_color (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_vld,
  input  wire fvcw_pkg::turn_t      ang,
  input  wire logic                 small_i,
  input  wire logic [16:0]          s16,
  output logic                      out_vld,
  output fvcw_pkg::chan_t           red,
  output fvcw_pkg::chan_t           green,
  output fvcw_pkg::chan_t           blue
);
  import fvcw_pkg::*;

  logic [2:0] vld_r;
  logic [38:0] pos;
  logic [5:0] k0, k1;
  logic [23:0] wheel_tab [WheelSize];

  // The wheel is a constant table; every entry is folded at elaboration.
  always_comb begin
    for (int k = 0; k < WheelSize; k++) wheel_tab[k] = wheel_entry(6'(k));
  end

  always_comb begin
    pos = (ang == '0) ? 39'(54) << 32 : 39'(ang) * 39'd54;
    k0 = (pos[38:32] > 7'd54) ? 6'd54 : pos[37:32];
    k1 = (k0 == 6'd54) ? 6'd0 : k0 + 6'd1;
  end

  logic [23:0] c0_r, c1_r;
  logic [15:0] f_r;
  logic sm1_r, sm2_r;
  logic [16:0] s2_r;
  chan_t b_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[1:0], in_vld};
  end

  // The square root arrives in the cycle after the angle, so it joins at the second stage.
  always_ff @(posedge clk) begin
    c0_r <= wheel_tab[k0];
    c1_r <= wheel_tab[k1];
    f_r <= pos[31:16];
    sm1_r <= small_i;
    sm2_r <= sm1_r;
    s2_r <= s16;
  end

  for (genvar j = 0; j < 3; j++) begin : g_ch
    logic [7:0] a, b;
    logic [25:0] pa, pb;
    logic [9:0] sum;
    logic [7:0] inv;
    logic [25:0] pd;
    logic [9:0] d;
    logic [9:0] dim;
    always_comb begin
      a = c0_r[8*(2-j) +: 8];
      b = c1_r[8*(2-j) +: 8];
      pa = 26'(a) * (26'h10000 - 26'(f_r)) + 26'd32768;
      pb = 26'(b) * 26'(f_r) + 26'd32768;
      sum = 10'(pa[25:16]) + 10'(pb[25:16]);
      inv = 8'd255 - b_r[j];
      pd = 26'(inv) * 26'(s2_r) + 26'd32768;
      d = pd[25:16];
      dim = (10'd3 * 10'(b_r[j]) + 10'd2) >> 2;
    end
    always_ff @(posedge clk) begin
      b_r[j] <= (sum > 10'd255) ? 8'd255 : sum[7:0];
    end
    chan_t o_r;
    always_ff @(posedge clk) begin
      if (sm2_r) o_r <= (d > 10'd255) ? 8'd0 : 8'(10'd255 - d);
      else o_r <= dim[7:0];
    end
    if (j == 0) begin : g_r
      assign red = o_r;
    end else if (j == 1) begin : g_g
      assign green = o_r;
    end else begin : g_b
      assign blue = o_r;
    end
  end

  assign out_vld = vld_r[2];

  `ASSERT_NEXT(a_pipe0, clk, rst_n, in_vld, vld_r[0], "color stage lost a valid")
  `ASSERT_NEXT(a_pipe2, clk, rst_n, vld_r[1], out_vld, "color stage lost a valid")
  `ASSERT_NEXT(a_sm, clk, rst_n, vld_r[0], sm2_r == $past(sm1_r), "length flag skewed")
endmodule
`default_nettype wire

// ===== rtl/core/flow_vector_color_wheel.sv =====
// Flow vector color wheel: takes a flow vector each cycle and gives its RGB color.
// busy is always low, so a new vector is taken every cycle. Each result is on the
// outputs with out_valid high for one cycle, after the 17-stage CORDIC angle pipeline
// and three color stages, with the square root running alongside.
// The receiver cannot stall the block.
`default_nettype none
module flow_vector_color_wheel #(
  parameter int FLOW_FRAC_BITS = fvcw_pkg::FlowFracBits
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [fvcw_pkg::FlowW-1:0] in_flow_u,
  input  wire logic signed [fvcw_pkg::FlowW-1:0] in_flow_v,
  output logic                                   out_valid,
  output fvcw_pkg::chan_t                        out_red,
  output fvcw_pkg::chan_t                        out_green,
  output fvcw_pkg::chan_t                        out_blue
);
  import fvcw_pkg::*;

  logic c_vld;
  turn_t ang;
  logic sm;
  logic [16:0] s16;

  assign busy = 1'b0;

  fvcw_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .in_vld(start), .u(in_flow_u), .v(in_flow_v),
    .out_vld(c_vld), .ang(ang)
  );

  fvcw_mag #(.FLOW_FRAC_BITS(FLOW_FRAC_BITS)) u_mag (
    .clk(clk), .u(in_flow_u), .v(in_flow_v), .small_o(sm), .s16(s16)
  );

  fvcw_color u_color (
    .clk(clk), .rst_n(rst_n), .in_vld(c_vld), .ang(ang), .small_i(sm), .s16(s16),
    .out_vld(out_valid), .red(out_red), .green(out_green), .blue(out_blue)
  );
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for flow_vector_color_wheel: drives flow vectors, predicts each color
// unless given, compares it with the output. Depends on fvcw_pkg and block RTL.
`timescale 1ns / 1ps
module tb;
  import fvcw_pkg::*;

  localparam int FracBits = FlowFracBits;
  localparam int Latency = 20;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [FlowW-1:0] in_flow_u;
  logic signed [FlowW-1:0] in_flow_v;
  logic out_valid;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  color_t pending_colors[$];
  int errors;
  int send_idle_pct;

  flow_vector_color_wheel DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_flow_u(in_flow_u),
    .in_flow_v(in_flow_v),
    .out_valid(out_valid),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Angle of the vector in 2^32 units of a turn, by vectoring CORDIC.
  function automatic logic [31:0] flow_turn(longint u, longint v);
    longint x, y, dx, dy;
    logic [31:0] ang;
    ang = 32'h0;
    if (v == 0) return (u > 0) ? 32'h0 : 32'h80000000;
    if (u == 0) return (v > 0) ? 32'h40000000 : 32'hC0000000;
    x = u * 65536;
    y = v * 65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h80000000;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        ang += turn_tab(i[3:0]);
      end else begin
        x -= dx;
        y += dy;
        ang -= turn_tab(i[3:0]);
      end
    end
    return ang;
  endfunction

  function automatic int hue_level(int k, int ch);
    int r, g, b;
    r = 0;
    g = 0;
    b = 0;
    if (k < 15) begin
      r = 255;
      g = 255 * k / 15;
    end else if (k < 21) begin
      r = 255 - 255 * (k - 15) / 6;
      g = 255;
    end else if (k < 25) begin
      g = 255;
      b = 255 * (k - 21) / 4;
    end else if (k < 36) begin
      g = 255 - 255 * (k - 25) / 11;
      b = 255;
    end else if (k < 49) begin
      r = 255 * (k - 36) / 13;
      b = 255;
    end else begin
      r = 255;
      b = 255 - 255 * ((k - 49 > 5) ? 5 : k - 49) / 6;
    end
    return (ch == 0) ? r : (ch == 1) ? g : b;
  endfunction

  function automatic longint unsigned scale_q16(longint unsigned c, longint unsigned w);
    return (c * w + 32768) >> 16;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic color_t flow_color(logic signed [FlowW-1:0] fu,
                                        logic signed [FlowW-1:0] fv);
    longint u, v;
    logic [31:0] ang;
    longint unsigned tq, pos, f, r2, one2, q, s16, s, d;
    int k0, k1;
    int col[3];
    color_t res;
    u = fu;
    v = fv;
    ang = flow_turn(u, v);
    tq = (ang == 0) ? (64'd1 << 32) : {32'h0, ang};
    pos = tq * (WheelSize - 1);
    k0 = int'(pos >> 32);
    f = (pos >> 16) & 64'hFFFF;
    if (k0 > WheelSize - 1) k0 = WheelSize - 1;
    k1 = (k0 + 1 >= WheelSize) ? 0 : k0 + 1;
    for (int j = 0; j < 3; j++) begin
      s = scale_q16(hue_level(k0, j), 65536 - f) + scale_q16(hue_level(k1, j), f);
      col[j] = (s > 255) ? 255 : int'(s);
    end
    r2 = u * u + v * v;
    one2 = 64'd1 << (2 * FracBits);
    if (r2 <= one2) begin
      q = (2 * FracBits <= 32) ? (r2 << (32 - 2 * FracBits)) : (r2 >> (2 * FracBits - 32));
      s16 = root_floor(q);
      if (s16 > 65536) s16 = 65536;
      for (int j = 0; j < 3; j++) begin
        d = scale_q16(255 - col[j], s16);
        col[j] = (d > 255) ? 0 : 255 - int'(d);
      end
    end else begin
      for (int j = 0; j < 3; j++) col[j] = (3 * col[j] + 2) >> 2;
    end
    res.red = col[0][7:0];
    res.green = col[1][7:0];
    res.blue = col[2][7:0];
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Sends one vector; the expected color is either given or predicted.
  task automatic send_flow(logic signed [FlowW-1:0] fu, logic signed [FlowW-1:0] fv,
                           bit has_color, color_t color);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_flow_u <= fu;
    in_flow_v <= fv;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_colors.insert(pending_colors.size(), has_color ? color : flow_color(fu, fv));
  endtask

  function automatic logic signed [FlowW-1:0] random_flow(int mode);
    logic signed [FlowW-1:0] val;
    case (mode)
      0: val = 24'($urandom);
      1: val = $signed(24'($urandom_range(8192))) - 24'sd4096;
      2: val = $signed(24'($urandom_range(6000))) - 24'sd3000;
      default: val = $signed(24'($urandom_range(64))) - 24'sd32;
    endcase
    return val;
  endfunction

  always @(posedge clk) begin
    color_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_red, out_green, out_blue};
      if (pending_colors.size() == 0) begin
        report_mismatch("color with nothing expected");
      end else begin
        want = pending_colors.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.blue));
      end
    end
  end

  typedef struct {
    logic signed [FlowW-1:0] fu;
    logic signed [FlowW-1:0] fv;
    bit has_color;
    color_t color;
  } flow_row_t;

  flow_row_t directed_rows[] = '{
    '{24'sd0, 24'sd0, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{24'sd4096, 24'sd0, 1'b1, '{8'd255, 8'd0, 8'd43}},
    '{24'sd8388607, 24'sd0, 1'b1, '{8'd191, 8'd0, 8'd32}},
    '{24'sh800000, 24'sd0, 1'b0, '0},
    '{24'sd0, 24'sd8388607, 1'b0, '0},
    '{24'sd0, 24'sh800000, 1'b0, '0},
    '{24'sh800000, 24'sh800000, 1'b0, '0},
    '{24'sd8388607, 24'sd8388607, 1'b0, '0},
    '{24'sd8388607, 24'sh800000, 1'b0, '0},
    '{24'sh800000, 24'sd8388607, 1'b0, '0},
    '{24'sd1, 24'sd0, 1'b0, '0},
    '{-24'sd1, -24'sd1, 1'b0, '0},
    '{24'sd2896, 24'sd2896, 1'b0, '0},
    '{-24'sd2048, 24'sd3547, 1'b0, '0},
    '{24'sd4096, 24'sd1, 1'b0, '0},
    '{24'sd4096, -24'sd1, 1'b0, '0},
    '{24'sd0, 24'sd4096, 1'b0, '0},
    '{24'sd0, 24'sd4097, 1'b0, '0},
    '{-24'sd4096, 24'sd0, 1'b0, '0},
    '{24'sd5555, -24'sd2222, 1'b0, '0},
    '{24'sh555555, 24'shAAAAAA, 1'b0, '0},
    '{24'shAAAAAA, 24'sh555555, 1'b0, '0}
  };

  initial begin
    int timeout;
    errors = 0;
    send_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_flow_u = '0;
    in_flow_v = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_flow(directed_rows[i].fu, directed_rows[i].fv, directed_rows[i].has_color,
                directed_rows[i].color);

    // Hold off until the pipeline has drained.
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);

    for (int n = 0; n < 2000; n++) begin
      send_idle_pct = (n < 700) ? 23 : (n < 1400) ? 63 : 0;
      send_flow(random_flow($urandom_range(3)), random_flow($urandom_range(3)), 1'b0, '0);
    end
    start <= 1'b0;

    timeout = 0;
    while (pending_colors.size() != 0 && timeout < 1000) begin
      @(posedge clk);
      timeout++;
    end
    repeat (Latency + 5) @(posedge clk);
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
